// ===== rtl/core/sm83_pkg.sv =====
// Package for the SM83 subset executor: beat layouts, opcodes and flag constants.
`timescale 1ns / 1ps

package sm83_pkg;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 80;

    localparam logic [7:0]  OP_PREFIX_CB = 8'hCB;
    localparam logic [7:0]  OP_HALT      = 8'h76;
    localparam logic [7:0]  OP_JR_NZ     = 8'h20;
    localparam logic [7:0]  OP_XOR_A     = 8'hAF;
    localparam logic [7:0]  OP_LDH_A8_A  = 8'hE0;
    localparam logic [7:0]  OP_LD_C_A    = 8'hE2;

    localparam logic [7:0]  CB_BIT_MASK  = 8'hC7;
    localparam logic [7:0]  CB_BIT_H     = 8'h44;

    localparam logic [3:0]  LO_LD_RR_D16 = 4'h1;
    localparam logic [3:0]  LO_ST_A      = 4'h2;
    localparam logic [3:0]  LO_INC_RR    = 4'h3;
    localparam logic [3:0]  LO_LD_A      = 4'hA;
    localparam logic [3:0]  LO_DEC_RR    = 4'hB;

    localparam logic [2:0]  IDX_HL_MEM   = 3'd6;
    localparam logic [1:0]  RP_HL        = 2'd2;
    localparam logic [1:0]  RP_HL_DEC    = 2'd3;

    localparam logic [7:0]  HIGH_PAGE    = 8'hFF;
    localparam logic [3:0]  FLAGS_XOR_A  = 4'b1000;

    localparam logic [4:0]  CYC_BYTE     = 5'd4;

    // Packed structs place the first member in the top bits, so fields are listed high to low.
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] imm_hi;
        logic [7:0] imm_lo;
        logic [7:0] cb_opcode;
        logic [7:0] opcode;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic        unknown_op;
        logic [4:0]  cycles;
        logic [7:0]  acc_out;
        logic [3:0]  flags_out;
        logic [15:0] pc_out;
        logic [7:0]  write_data;
        logic [15:0] write_addr;
        logic        write_en;
        logic        read_en;
        logic [15:0] read_addr;
    } out_beat_t;

endpackage

// ===== rtl/core/sm83_cpu_subset_execute.sv =====
// Top level of the SM83 subset executor: input register, single-pass execute and result register.
// A beat accepted on the s_ channel is held in the input register, executed combinationally and
// loaded into the result register that drives m_tdata and m_tvalid; a stalled result delays the load.
// Throughput: one instruction per cycle while m_tready is high; the register file, flags and PC
// update in the same cycle as the result register loads, so the next beat sees them at once.
// Reset (aresetn low, synchronous) clears the register file, the flags, SP, PC and both valid flags.
`timescale 1ns / 1ps

module sm83_cpu_subset_execute
    import sm83_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode, cb_opcode, imm_lo, imm_hi, read_data (8 bits each, from the lowest bit up)
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_addr, read_en, write_en, write_addr, write_data, pc_out, flags_out, acc_out,
    // cycles, unknown_op, then four zero bits
    output logic [M_TDATA_W-1:0] m_tdata
);

    in_beat_t    in_reg;
    logic        in_valid_reg;
    out_beat_t   out_reg, out_next;
    logic        out_valid_reg;
    logic        fire;

    logic [7:0]  a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg;
    logic [7:0]  a_next, b_next, c_next, d_next, e_next, h_next, l_next;
    logic [3:0]  flags_reg, flags_next;
    logic [15:0] sp_reg, sp_next, pc_reg, pc_next;

    logic [7:0]  gpr [8];
    logic [15:0] rp [4];

    logic [7:0]  op, cb, lo, hi, rdat;
    logic [15:0] hl;
    logic [4:0]  cyc;
    logic        wr8_en, wr16_en;
    logic [2:0]  wr8_idx;
    logic [1:0]  wr16_idx;
    logic [7:0]  wr8_val, operand, incdec;
    logic [15:0] wr16_val, addr_rp;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        op   = in_reg.opcode;
        cb   = in_reg.cb_opcode;
        lo   = in_reg.imm_lo;
        hi   = in_reg.imm_hi;
        rdat = in_reg.read_data;
        hl   = {h_reg, l_reg};

        gpr[0] = b_reg;
        gpr[1] = c_reg;
        gpr[2] = d_reg;
        gpr[3] = e_reg;
        gpr[4] = h_reg;
        gpr[5] = l_reg;
        gpr[6] = 8'h00;
        gpr[7] = a_reg;
        rp[0]  = {b_reg, c_reg};
        rp[1]  = {d_reg, e_reg};
        rp[2]  = hl;
        rp[3]  = sp_reg;

        out_next   = '0;
        pc_next    = pc_reg + 16'd1;
        cyc        = CYC_BYTE;
        flags_next = flags_reg;
        a_next     = a_reg;
        wr8_en     = 1'b0;
        wr8_idx    = op[5:3];
        wr8_val    = 8'h00;
        wr16_en    = 1'b0;
        wr16_idx   = op[5:4];
        wr16_val   = 16'h0000;
        operand    = (op[5:3] == IDX_HL_MEM) ? rdat : gpr[op[5:3]];
        incdec     = op[0] ? operand - 8'd1 : operand + 8'd1;
        addr_rp    = op[5] ? hl : rp[op[5:4]];

        if (op == OP_PREFIX_CB) begin
            pc_next = pc_next + 16'd1;
            cyc     = cyc + CYC_BYTE;
            if ((cb & CB_BIT_MASK) == CB_BIT_H) begin
                flags_next = {!h_reg[cb[5:3]], 1'b0, 1'b1, flags_reg[0]};
            end else begin
                out_next.unknown_op = 1'b1;
            end
        end else if (op inside {[8'h40:8'h7F]}) begin
            if (op == OP_HALT) begin
                out_next.unknown_op = 1'b1;
            end else begin
                wr8_val = gpr[op[2:0]];
                if (op[2:0] == IDX_HL_MEM) begin
                    out_next.read_en   = 1'b1;
                    out_next.read_addr = hl;
                    wr8_val            = rdat;
                    cyc                = cyc + CYC_BYTE;
                end
                if (op[5:3] == IDX_HL_MEM) begin
                    out_next.write_en   = 1'b1;
                    out_next.write_addr = hl;
                    out_next.write_data = wr8_val;
                    cyc                 = cyc + CYC_BYTE;
                end else begin
                    wr8_en = 1'b1;
                end
            end
        end else if (op == OP_JR_NZ) begin
            pc_next = pc_next + 16'd1;
            cyc     = cyc + CYC_BYTE;
            if (!flags_reg[3]) begin
                pc_next = pc_next + {{8{lo[7]}}, lo};
                cyc     = cyc + CYC_BYTE;
            end
        end else if (op[7:6] == 2'b00 && op[2:1] == 2'b10) begin
            flags_next = {incdec == 8'h00, op[0],
                          op[0] ? (incdec[3:0] == 4'hF) : (incdec[3:0] == 4'h0),
                          flags_reg[0]};
            if (op[5:3] == IDX_HL_MEM) begin
                out_next.read_en    = 1'b1;
                out_next.read_addr  = hl;
                out_next.write_en   = 1'b1;
                out_next.write_addr = hl;
                out_next.write_data = incdec;
                cyc                 = cyc + CYC_BYTE + CYC_BYTE;
            end else begin
                wr8_en  = 1'b1;
                wr8_val = incdec;
            end
        end else if (op[7:6] == 2'b00 && op[2:0] == IDX_HL_MEM) begin
            pc_next = pc_next + 16'd1;
            cyc     = cyc + CYC_BYTE;
            if (op[5:3] == IDX_HL_MEM) begin
                out_next.write_en   = 1'b1;
                out_next.write_addr = hl;
                out_next.write_data = lo;
                cyc                 = cyc + CYC_BYTE;
            end else begin
                wr8_en  = 1'b1;
                wr8_val = lo;
            end
        end else if (op[7:6] == 2'b00) begin
            case (op[3:0])
                LO_LD_RR_D16: begin
                    wr16_en  = 1'b1;
                    wr16_val = {hi, lo};
                    pc_next  = pc_next + 16'd2;
                    cyc      = cyc + CYC_BYTE + CYC_BYTE;
                end
                LO_INC_RR: begin
                    wr16_en  = 1'b1;
                    wr16_val = rp[op[5:4]] + 16'd1;
                    cyc      = cyc + CYC_BYTE;
                end
                LO_DEC_RR: begin
                    wr16_en  = 1'b1;
                    wr16_val = rp[op[5:4]] - 16'd1;
                    cyc      = cyc + CYC_BYTE;
                end
                LO_ST_A, LO_LD_A: begin
                    cyc = cyc + CYC_BYTE;
                    if (op[3]) begin
                        out_next.read_en   = 1'b1;
                        out_next.read_addr = addr_rp;
                        a_next             = rdat;
                    end else begin
                        out_next.write_en   = 1'b1;
                        out_next.write_addr = addr_rp;
                        out_next.write_data = a_reg;
                    end
                    wr16_idx = RP_HL;
                    wr16_en  = op[5];
                    wr16_val = (op[5:4] == RP_HL_DEC) ? hl - 16'd1 : hl + 16'd1;
                end
                default: begin
                    out_next.unknown_op = 1'b1;
                end
            endcase
        end else if (op == OP_XOR_A) begin
            a_next     = 8'h00;
            flags_next = FLAGS_XOR_A;
        end else if (op == OP_LDH_A8_A) begin
            pc_next             = pc_next + 16'd1;
            cyc                 = cyc + CYC_BYTE + CYC_BYTE;
            out_next.write_en   = 1'b1;
            out_next.write_addr = {HIGH_PAGE, lo};
            out_next.write_data = a_reg;
        end else if (op == OP_LD_C_A) begin
            cyc                 = cyc + CYC_BYTE;
            out_next.write_en   = 1'b1;
            out_next.write_addr = {HIGH_PAGE, c_reg};
            out_next.write_data = a_reg;
        end else begin
            out_next.unknown_op = 1'b1;
        end

        b_next  = b_reg;
        c_next  = c_reg;
        d_next  = d_reg;
        e_next  = e_reg;
        h_next  = h_reg;
        l_next  = l_reg;
        sp_next = sp_reg;
        if (wr8_en) begin
            case (wr8_idx)
                3'd0:    b_next = wr8_val;
                3'd1:    c_next = wr8_val;
                3'd2:    d_next = wr8_val;
                3'd3:    e_next = wr8_val;
                3'd4:    h_next = wr8_val;
                3'd5:    l_next = wr8_val;
                3'd7:    a_next = wr8_val;
                default: ;
            endcase
        end
        if (wr16_en) begin
            case (wr16_idx)
                2'd0:    {b_next, c_next} = wr16_val;
                2'd1:    {d_next, e_next} = wr16_val;
                2'd2:    {h_next, l_next} = wr16_val;
                default: sp_next = wr16_val;
            endcase
        end

        out_next.pc_out    = pc_next;
        out_next.flags_out = flags_next;
        out_next.acc_out   = a_next;
        out_next.cycles    = cyc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            e_reg         <= '0;
            h_reg         <= '0;
            l_reg         <= '0;
            flags_reg     <= '0;
            sp_reg        <= '0;
            pc_reg        <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                a_reg         <= a_next;
                b_reg         <= b_next;
                c_reg         <= c_next;
                d_reg         <= d_next;
                e_reg         <= e_next;
                h_reg         <= h_next;
                l_reg         <= l_next;
                flags_reg     <= flags_next;
                sp_reg        <= sp_next;
                pc_reg        <= pc_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= in_beat_t'(s_tdata);
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

    // The beat on show always reflects the architectural state it left behind.
    a_state_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.pc_out == pc_reg && out_reg.acc_out == a_reg &&
                           out_reg.flags_out == flags_reg))
        else $error("result beat does not match the state registers");

    a_unknown_keeps_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && out_next.unknown_op |=> $stable(flags_reg) && $stable(a_reg) && $stable(hl))
        else $error("unknown opcode changed register state");

    a_cycles_whole: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.cycles[1:0] == 2'b00 && out_reg.cycles != 5'd0))
        else $error("cycle count is not a whole number of machine cycles");

    a_idle_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.write_en |->
            (out_reg.write_addr == 16'h0000 && out_reg.write_data == 8'h00))
        else $error("write fields set without a write");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> $stable(pc_reg) && $stable(sp_reg))
        else $error("state advanced while the result beat was stalled");

endmodule

// ===== tb/sm83_exec_checker.sv =====
// Checker for the SM83 subset executor: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps

module sm83_exec_checker
    import sm83_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   error_count,
    output int                   pending_count
);

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_C = 0;

    localparam logic [2:0] R_C = 3'd1;
    localparam logic [2:0] R_H = 3'd4;
    localparam logic [2:0] R_L = 3'd5;
    localparam logic [2:0] R_A = 3'd7;

    localparam logic [1:0] RP_BC = 2'd0;
    localparam logic [1:0] RP_DE = 2'd1;

    localparam logic [2:0] LO3_INC_R  = 3'd4;
    localparam logic [2:0] LO3_DEC_R  = 3'd5;
    localparam logic [2:0] LO3_LD_D8  = 3'd6;

    logic [7:0]  gpr [8];
    logic [3:0]  flags_q;
    logic [15:0] sp_q;
    logic [15:0] pc_q;

    out_beat_t   expected_results [$];
    int          mismatch_count;
    int          beat_count;

    assign error_count   = mismatch_count;
    assign pending_count = expected_results.size();

    function automatic logic [15:0] pair_read(input logic [1:0] p);
        case (p)
            RP_BC:   return {gpr[0], gpr[R_C]};
            RP_DE:   return {gpr[2], gpr[3]};
            RP_HL:   return {gpr[R_H], gpr[R_L]};
            default: return sp_q;
        endcase
    endfunction

    function automatic void pair_write(input logic [1:0] p, input logic [15:0] v);
        case (p)
            RP_BC:   {gpr[0], gpr[R_C]} = v;
            RP_DE:   {gpr[2], gpr[3]}   = v;
            RP_HL:   {gpr[R_H], gpr[R_L]} = v;
            default: sp_q = v;
        endcase
    endfunction

    function automatic logic [7:0] step_byte(input logic [7:0] v, input logic dec);
        logic [7:0] res;
        res = dec ? v - 8'd1 : v + 8'd1;
        flags_q = {res == 8'd0, dec,
                   dec ? (res[3:0] == 4'hF) : (res[3:0] == 4'h0), flags_q[FLAG_C]};
        return res;
    endfunction

    function automatic out_beat_t execute_instr(input in_beat_t ib);
        out_beat_t   r;
        logic [15:0] next_pc;
        logic [15:0] hl;
        logic [15:0] addr;
        logic [2:0]  k;
        logic [2:0]  src;
        logic [1:0]  p;
        logic [7:0]  v;
        r       = '0;
        r.cycles = CYC_BYTE;
        next_pc = pc_q + 16'd1;
        hl      = pair_read(RP_HL);
        k       = ib.opcode[5:3];
        src     = ib.opcode[2:0];
        p       = ib.opcode[5:4];
        if (ib.opcode == OP_PREFIX_CB) begin
            next_pc  += 16'd1;
            r.cycles += CYC_BYTE;
            if ((ib.cb_opcode & CB_BIT_MASK) == CB_BIT_H) begin
                flags_q = {~gpr[R_H][ib.cb_opcode[5:3]], 1'b0, 1'b1, flags_q[FLAG_C]};
            end else begin
                r.unknown_op = 1'b1;
            end
        end else if (ib.opcode[7:6] == 2'b01) begin
            if (ib.opcode == OP_HALT) begin
                r.unknown_op = 1'b1;
            end else begin
                if (src == IDX_HL_MEM) begin
                    r.read_en   = 1'b1;
                    r.read_addr = hl;
                    v           = ib.read_data;
                    r.cycles   += CYC_BYTE;
                end else begin
                    v = gpr[src];
                end
                if (k == IDX_HL_MEM) begin
                    r.write_en   = 1'b1;
                    r.write_addr = hl;
                    r.write_data = v;
                    r.cycles    += CYC_BYTE;
                end else begin
                    gpr[k] = v;
                end
            end
        end else if (ib.opcode == OP_JR_NZ) begin
            next_pc  += 16'd1;
            r.cycles += CYC_BYTE;
            if (!flags_q[FLAG_Z]) begin
                next_pc  += {{8{ib.imm_lo[7]}}, ib.imm_lo};
                r.cycles += CYC_BYTE;
            end
        end else if (ib.opcode[7:6] == 2'b00 && (src == LO3_INC_R || src == LO3_DEC_R)) begin
            if (k == IDX_HL_MEM) begin
                r.read_en    = 1'b1;
                r.read_addr  = hl;
                r.write_en   = 1'b1;
                r.write_addr = hl;
                r.write_data = step_byte(ib.read_data, src == LO3_DEC_R);
                r.cycles    += CYC_BYTE + CYC_BYTE;
            end else begin
                gpr[k] = step_byte(gpr[k], src == LO3_DEC_R);
            end
        end else if (ib.opcode[7:6] == 2'b00 && src == LO3_LD_D8) begin
            next_pc  += 16'd1;
            r.cycles += CYC_BYTE;
            if (k == IDX_HL_MEM) begin
                r.write_en   = 1'b1;
                r.write_addr = hl;
                r.write_data = ib.imm_lo;
                r.cycles    += CYC_BYTE;
            end else begin
                gpr[k] = ib.imm_lo;
            end
        end else if (ib.opcode[7:6] == 2'b00) begin
            addr = (p == RP_BC || p == RP_DE) ? pair_read(p) : hl;
            case (ib.opcode[3:0])
                LO_LD_RR_D16: begin
                    pair_write(p, {ib.imm_hi, ib.imm_lo});
                    next_pc  += 16'd2;
                    r.cycles += CYC_BYTE + CYC_BYTE;
                end
                LO_INC_RR: begin
                    pair_write(p, pair_read(p) + 16'd1);
                    r.cycles += CYC_BYTE;
                end
                LO_DEC_RR: begin
                    pair_write(p, pair_read(p) - 16'd1);
                    r.cycles += CYC_BYTE;
                end
                LO_ST_A, LO_LD_A: begin
                    if (ib.opcode[3:0] == LO_ST_A) begin
                        r.write_en   = 1'b1;
                        r.write_addr = addr;
                        r.write_data = gpr[R_A];
                    end else begin
                        r.read_en    = 1'b1;
                        r.read_addr  = addr;
                        gpr[R_A]     = ib.read_data;
                    end
                    r.cycles += CYC_BYTE;
                    if (p == RP_HL) pair_write(RP_HL, hl + 16'd1);
                    if (p == RP_HL_DEC) pair_write(RP_HL, hl - 16'd1);
                end
                default: r.unknown_op = 1'b1;
            endcase
        end else if (ib.opcode == OP_XOR_A) begin
            gpr[R_A] = 8'd0;
            flags_q  = FLAGS_XOR_A;
        end else if (ib.opcode == OP_LDH_A8_A) begin
            next_pc     += 16'd1;
            r.write_en   = 1'b1;
            r.write_addr = {HIGH_PAGE, ib.imm_lo};
            r.write_data = gpr[R_A];
            r.cycles    += CYC_BYTE + CYC_BYTE;
        end else if (ib.opcode == OP_LD_C_A) begin
            r.write_en   = 1'b1;
            r.write_addr = {HIGH_PAGE, gpr[R_C]};
            r.write_data = gpr[R_A];
            r.cycles    += CYC_BYTE;
        end else begin
            r.unknown_op = 1'b1;
        end
        pc_q        = next_pc;
        r.pc_out    = pc_q;
        r.flags_out = flags_q;
        r.acc_out   = gpr[R_A];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Mismatch on result beat %0d, %s: expected 0x%0h, got 0x%0h",
                         beat_count, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        out_beat_t got;
        if (!aresetn) begin
            foreach (gpr[i]) gpr[i] = 8'd0;
            flags_q = 4'd0;
            sp_q    = 16'd0;
            pc_q    = 16'd0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(execute_instr(in_beat_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                got = out_beat_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result beat %0d: 0x%0h", beat_count, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_addr",  want.read_addr,       got.read_addr);
                    check_field("read_en",    16'(want.read_en),    16'(got.read_en));
                    check_field("write_en",   16'(want.write_en),   16'(got.write_en));
                    check_field("write_addr", want.write_addr,      got.write_addr);
                    check_field("write_data", 16'(want.write_data), 16'(got.write_data));
                    check_field("pc_out",     want.pc_out,          got.pc_out);
                    check_field("flags_out",  16'(want.flags_out),  16'(got.flags_out));
                    check_field("acc_out",    16'(want.acc_out),    16'(got.acc_out));
                    check_field("cycles",     16'(want.cycles),     16'(got.cycles));
                    check_field("unknown_op", 16'(want.unknown_op), 16'(got.unknown_op));
                    check_field("pad",        16'(want.pad),        16'(got.pad));
                end
                beat_count++;
            end
        end
    end

    initial begin
        mismatch_count = 0;
        beat_count     = 0;
    end

endmodule

// ===== tb/sm83_cpu_subset_execute_test.sv =====
// Testbench top for the SM83 subset executor: clock, reset, instruction stream and verdict.
`timescale 1ns / 1ps

module sm83_cpu_subset_execute_test;
    import sm83_pkg::*;

    localparam int unsigned RANDOM_INSTRS = 400;
    localparam int unsigned CALM_FROM     = 340;
    localparam int unsigned STALL_LIMIT   = 1000;

    localparam logic [7:0] OP_NOP        = 8'h00;
    localparam logic [7:0] OP_LD_BC_D16  = 8'h01;
    localparam logic [7:0] OP_LD_BCM_A   = 8'h02;
    localparam logic [7:0] OP_LD_A_DEM   = 8'h1A;
    localparam logic [7:0] OP_LD_HL_D16  = 8'h21;
    localparam logic [7:0] OP_LD_HLI_A   = 8'h22;
    localparam logic [7:0] OP_INC_HL     = 8'h23;
    localparam logic [7:0] OP_LD_H_D8    = 8'h26;
    localparam logic [7:0] OP_LD_A_HLI   = 8'h2A;
    localparam logic [7:0] OP_DEC_HL     = 8'h2B;
    localparam logic [7:0] OP_LD_HLD_A   = 8'h32;
    localparam logic [7:0] OP_INC_HLM    = 8'h34;
    localparam logic [7:0] OP_DEC_HLM    = 8'h35;
    localparam logic [7:0] OP_LD_HLM_D8  = 8'h36;
    localparam logic [7:0] OP_INC_A      = 8'h3C;
    localparam logic [7:0] OP_DEC_A      = 8'h3D;
    localparam logic [7:0] OP_LD_A_D8    = 8'h3E;
    localparam logic [7:0] OP_LD_B_HLM   = 8'h46;
    localparam logic [7:0] OP_LD_HLM_B   = 8'h70;
    localparam logic [7:0] CB_RLC_B      = 8'h00;
    localparam logic [7:0] CB_BIT_7_H    = 8'h7C;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int error_count;
    int pending_count;
    bit idle_on = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    sm83_cpu_subset_execute i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sm83_exec_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_instr(input logic [7:0] op, input logic [7:0] cb, input logic [7:0] lo,
                              input logic [7:0] hi, input logic [7:0] rd);
        in_beat_t ib;
        ib.opcode    = op;
        ib.cb_opcode = cb;
        ib.imm_lo    = lo;
        ib.imm_hi    = hi;
        ib.read_data = rd;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ib;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 9))
            0, 1:    return 8'h40 | 8'($urandom_range(0, 63));
            2:       return {2'b00, 3'($urandom), 2'b10, 1'($urandom)};
            3:       return {2'b00, 3'($urandom), 3'd6};
            4:       begin
                         case ($urandom_range(0, 4))
                             0:       return {2'b00, 2'($urandom), LO_LD_RR_D16};
                             1:       return {2'b00, 2'($urandom), LO_ST_A};
                             2:       return {2'b00, 2'($urandom), LO_INC_RR};
                             3:       return {2'b00, 2'($urandom), LO_LD_A};
                             default: return {2'b00, 2'($urandom), LO_DEC_RR};
                         endcase
                     end
            5:       return OP_JR_NZ;
            6:       begin
                         case ($urandom_range(0, 3))
                             0:       return OP_XOR_A;
                             1:       return OP_LDH_A8_A;
                             2:       return OP_LD_C_A;
                             default: return OP_PREFIX_CB;
                         endcase
                     end
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] op;
        logic [7:0] cb;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_instr(OP_NOP,       8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_HALT,      8'hFF,      8'hFF, 8'hFF, 8'hFF);
        send_instr(OP_PREFIX_CB, CB_RLC_B,   8'h00, 8'h00, 8'h00);
        send_instr(OP_JR_NZ,     8'h00,      8'h80, 8'h00, 8'h00);
        send_instr(OP_LD_HL_D16, 8'h00,      8'hFF, 8'hFF, 8'h00);
        send_instr(OP_INC_HL,    8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_DEC_HL,    8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_LD_A_D8,   8'h00,      8'hFF, 8'h00, 8'h00);
        send_instr(OP_INC_A,     8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_DEC_A,     8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_JR_NZ,     8'h00,      8'h7F, 8'h00, 8'h00);
        send_instr(OP_XOR_A,     8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_JR_NZ,     8'h00,      8'h05, 8'h00, 8'h00);
        send_instr(OP_PREFIX_CB, CB_BIT_7_H, 8'h00, 8'h00, 8'h00);
        send_instr(OP_LD_H_D8,   8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_PREFIX_CB, CB_BIT_H,   8'h00, 8'h00, 8'h00);
        send_instr(OP_INC_HLM,   8'h00,      8'h00, 8'h00, 8'hFF);
        send_instr(OP_DEC_HLM,   8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_LD_HLM_D8, 8'h00,      8'hA5, 8'h00, 8'h00);
        send_instr(OP_LD_HLI_A,  8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_LD_HLD_A,  8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_LD_A_HLI,  8'h00,      8'h00, 8'h00, 8'h5A);
        send_instr(OP_LD_BC_D16, 8'h00,      8'h34, 8'h12, 8'h00);
        send_instr(OP_LD_BCM_A,  8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_LD_A_DEM,  8'h00,      8'h00, 8'h00, 8'hC3);
        send_instr(OP_LDH_A8_A,  8'h00,      8'hFF, 8'h00, 8'h00);
        send_instr(OP_LD_C_A,    8'h00,      8'h00, 8'h00, 8'h00);
        send_instr(OP_LD_B_HLM,  8'h00,      8'h00, 8'h00, 8'h77);
        send_instr(OP_LD_HLM_B,  8'h00,      8'h00, 8'h00, 8'h00);

        // Idling is switched off for one window in three and for the whole tail of the run.
        for (int i = 0; i < RANDOM_INSTRS; i++) begin
            idle_on = (i < CALM_FROM) && ((i / 40) % 3 != 2);
            op = pick_opcode();
            cb = ($urandom_range(0, 9) < 6) ? {2'b01, 3'($urandom), 3'b100} : 8'($urandom);
            send_instr(op, cb, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        if (error_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
